### sv/text_console_cursor_scroll_top_assert.svh
// assertion macros shared by the console engine rtl
// depends on clk and rst_n being visible where a macro is used
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_TOP_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_TOP_ASSERT_SVH

// condition must hold at every edge out of reset
`define TCCS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence must hold in the same cycle as the antecedent
`define TCCS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### sv/tccs_pkg.sv
// shared types and codes of the text console engine
// no dependencies
package tccs_pkg;

  // request and result payloads
  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] character;
    logic [7:0] column;
    logic [7:0] row;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] cursor_position;
  } out_item_t;

  // operation codes
  localparam logic [1:0] OP_PRINT = 2'd0;
  localparam logic [1:0] OP_MOVE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // control characters
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_TAB     = 8'd9;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BOUNDS    = 2'd1;
  localparam logic [1:0] ST_NO_SCROLL = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_TEXT_COLOR   = 2'd0;
  localparam logic [1:0] CFG_BLANK_CHAR   = 2'd1;
  localparam logic [1:0] CFG_SCROLL_EN    = 2'd2;

  // classified command passed from front to back
  typedef enum logic [2:0] {
    CMD_PUT,
    CMD_NEWLINE,
    CMD_TAB,
    CMD_MOVE,
    CMD_MOVE_BAD,
    CMD_CLEAR,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] character;
    logic [7:0] column;
    logic [7:0] row;
  } cmd_t;

  // configuration seen by the back end
  typedef struct packed {
    logic [7:0] text_color;
    logic [7:0] blank_character;
    logic       scroll_enable;
  } cfg_t;

endpackage

### sv/tccs_stream_if.sv
// valid/ready stream channel used for requests and results
// payload type is set by the instantiating scope
interface tccs_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

### sv/tccs_front.sv
// front end: takes requests and classifies them into commands
// depends on tccs_pkg and tccs_stream_if
module tccs_front import tccs_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  tccs_stream_if.sink in_if,
  input  logic        hold,
  input  logic        q_full,
  output logic        push,
  output cmd_t        cmd
);

  logic col_ok;
  logic row_ok;

  // handshake: stop while the queue is full or the buffer is being swept after reset
  assign in_if.ready = !q_full && !hold;
  assign push        = in_if.valid && in_if.ready;

  // bounds check for cursor moves
  assign col_ok = {1'b0, in_if.payload.column} < 9'(COLUMNS);
  assign row_ok = {1'b0, in_if.payload.row} < 9'(ROWS);

  // decode operation and control characters
  always_comb begin
    cmd.character = in_if.payload.character;
    cmd.column    = in_if.payload.column;
    cmd.row       = in_if.payload.row;
    case (in_if.payload.operation)
      OP_PRINT: begin
        if (in_if.payload.character == CHAR_NEWLINE) begin
          cmd.kind = CMD_NEWLINE;
        end else if (in_if.payload.character == CHAR_TAB) begin
          cmd.kind = CMD_TAB;
        end else begin
          cmd.kind = CMD_PUT;
        end
      end
      OP_MOVE: begin
        cmd.kind = (col_ok && row_ok) ? CMD_MOVE : CMD_MOVE_BAD;
      end
      OP_CLEAR: begin
        cmd.kind = CMD_CLEAR;
      end
      default: begin
        cmd.kind = CMD_NOP;
      end
    endcase
  end

endmodule

### sv/tccs_fifo.sv
// two-entry command queue between front and back end
// depends on tccs_pkg
module tccs_fifo import tccs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  input  logic pop,
  output logic not_empty,
  output logic full,
  output cmd_t dout
);

  cmd_t       entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign not_empty = count_r != 2'd0;
  assign full      = count_r == 2'd2;
  assign dout      = entry_r[rd_ptr_r];

  // payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= din;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

endmodule

### sv/tccs_back.sv
// back end: cursor state, cell memory sequencer and result register
// depends on tccs_pkg, tccs_stream_if and the assertion macro header
`include "text_console_cursor_scroll_top_assert.svh"

module tccs_back import tccs_pkg::*; #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  input  logic          q_valid,
  input  cmd_t          q_cmd,
  output logic          q_pop,
  output logic          init_busy,
  tccs_stream_if.source out_if
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int TW    = $clog2(TAB_WIDTH + 1);

  localparam logic [AW-1:0] LAST_BASE = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
  localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_TAB,
    S_SCROLL,
    S_BLANK,
    S_CLEAR,
    S_FINISH
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  logic [AW-1:0]   base_r, base_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [AW-1:0]   pidx_r, pidx_nxt;
  logic            pend_r, pend_nxt;
  logic [TW-1:0]   tab_left_r, tab_left_nxt;
  logic [1:0]      status_r, status_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  // cell memory
  logic [15:0]     cell_mem [CELLS];
  logic [15:0]     rdata_r;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [15:0]     mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;

  // cursor step helpers
  logic [AW-1:0]   lin;
  logic            last_col;
  logic            last_row;
  logic            at_end;
  logic [CW-1:0]   adv_col;
  logic [RW-1:0]   adv_row;
  logic [AW-1:0]   adv_base;
  logic [CW-1:0]   nl_col;
  logic [RW-1:0]   nl_row;
  logic [AW-1:0]   nl_base;
  logic [AW-1:0]   move_base;
  logic            out_free;
  logic            out_load;
  logic [15:0]     blank_cell;
  logic [TW-1:0]   tab_dec;

  assign lin        = base_r + AW'(col_r);
  assign last_col   = col_r == LAST_COL;
  assign last_row   = row_r == LAST_ROW;
  assign at_end     = last_col && last_row;
  assign move_base  = AW'(int'(q_cmd.row) * COLUMNS);
  assign blank_cell = {cfg.text_color, cfg.blank_character};
  assign tab_dec    = tab_left_r - TW'(1);
  assign out_free   = !out_valid_r || out_if.ready;
  assign init_busy  = state_r == S_INIT;

  assign out_if.valid   = out_valid_r;
  assign out_if.payload = out_data_r;

  // one-cell advance; at the last cell either the scroll target or a hold
  always_comb begin
    adv_col  = col_r;
    adv_row  = row_r;
    adv_base = base_r;
    if (!last_col) begin
      adv_col = col_r + CW'(1);
    end else if (!last_row) begin
      adv_col  = '0;
      adv_row  = row_r + RW'(1);
      adv_base = base_r + ROW_STEP;
    end else if (cfg.scroll_enable) begin
      adv_col = '0;
    end
  end

  // newline; on the last row either the scroll target or the last cell
  always_comb begin
    nl_col  = '0;
    nl_row  = row_r;
    nl_base = base_r;
    if (!last_row) begin
      nl_row  = row_r + RW'(1);
      nl_base = base_r + ROW_STEP;
    end else if (!cfg.scroll_enable) begin
      nl_col = LAST_COL;
    end
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    base_nxt     = base_r;
    idx_nxt      = idx_r;
    pidx_nxt     = pidx_r;
    pend_nxt     = 1'b0;
    tab_left_nxt = tab_left_r;
    status_nxt   = status_r;
    q_pop        = 1'b0;
    out_load     = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = lin;
    mem_wdata    = blank_cell;
    mem_re       = 1'b0;
    mem_raddr    = idx_r + ROW_STEP;

    case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = '0;
        if (idx_r == LAST_CELL) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop        = 1'b1;
          idx_nxt      = '0;
          tab_left_nxt = '0;
          status_nxt   = ST_OK;
          case (q_cmd.kind)
            CMD_PUT: begin
              mem_we    = 1'b1;
              mem_wdata = {cfg.text_color, q_cmd.character};
              col_nxt   = adv_col;
              row_nxt   = adv_row;
              base_nxt  = adv_base;
              if (at_end && cfg.scroll_enable) begin
                state_nxt = S_SCROLL;
              end else begin
                out_load = 1'b1;
                if (at_end) begin
                  status_nxt = ST_NO_SCROLL;
                end
              end
            end
            CMD_NEWLINE: begin
              col_nxt  = nl_col;
              row_nxt  = nl_row;
              base_nxt = nl_base;
              if (last_row && cfg.scroll_enable) begin
                state_nxt = S_SCROLL;
              end else begin
                out_load = 1'b1;
                if (last_row) begin
                  status_nxt = ST_NO_SCROLL;
                end
              end
            end
            CMD_TAB: begin
              tab_left_nxt = TW'(TAB_WIDTH);
              state_nxt    = S_TAB;
            end
            CMD_MOVE: begin
              col_nxt  = CW'(q_cmd.column);
              row_nxt  = RW'(q_cmd.row);
              base_nxt = move_base;
              out_load = 1'b1;
            end
            CMD_MOVE_BAD: begin
              status_nxt = ST_BOUNDS;
              out_load   = 1'b1;
            end
            CMD_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = '0;
              base_nxt  = '0;
              state_nxt = S_CLEAR;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_TAB: begin
        mem_we       = 1'b1;
        col_nxt      = adv_col;
        row_nxt      = adv_row;
        base_nxt     = adv_base;
        tab_left_nxt = tab_dec;
        if (at_end && !cfg.scroll_enable) begin
          status_nxt = ST_NO_SCROLL;
        end
        if (at_end && cfg.scroll_enable) begin
          idx_nxt   = '0;
          state_nxt = S_SCROLL;
        end else if (tab_dec == '0) begin
          state_nxt = S_FINISH;
        end
      end
      S_SCROLL: begin
        // copy one row up: read ahead one row, write the previous read
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pidx_r;
          mem_wdata = rdata_r;
        end
        if (idx_r != LAST_BASE) begin
          mem_re   = 1'b1;
          pend_nxt = 1'b1;
          pidx_nxt = idx_r;
          idx_nxt  = idx_r + AW'(1);
        end else begin
          state_nxt = S_BLANK;
        end
      end
      S_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        if (idx_r == LAST_CELL) begin
          idx_nxt   = '0;
          state_nxt = (tab_left_r != '0) ? S_TAB : S_FINISH;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        if (idx_r == LAST_CELL) begin
          idx_nxt   = '0;
          state_nxt = S_FINISH;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt                = 1'b1;
      out_data_nxt.status          = status_nxt;
      out_data_nxt.cursor_position = 11'(base_nxt + AW'(col_nxt));
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      col_r       <= '0;
      row_r       <= '0;
      base_r      <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      tab_left_r  <= '0;
      status_r    <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      base_r      <= base_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      tab_left_r  <= tab_left_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pidx_r     <= pidx_nxt;
    out_data_r <= out_data_nxt;
  end

  // cell memory ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= cell_mem[mem_raddr];
    end
  end

  `TCCS_ASSERT_ALWAYS(a_cursor_in_screen, (int'(col_r) < COLUMNS) && (int'(row_r) < ROWS), "cursor left the screen")
  `TCCS_ASSERT_ALWAYS(a_base_matches_row, int'(base_r) == int'(row_r) * COLUMNS, "row base out of step with row")
  `TCCS_ASSERT_IMPLY(a_pop_only_idle, q_pop, state_r == S_IDLE, "command taken while busy")
  `TCCS_ASSERT_IMPLY(a_load_slot_free, out_load, !out_valid_r || out_if.ready, "result overwritten before taken")
  `TCCS_ASSERT_IMPLY(a_write_in_range, mem_we, int'(mem_waddr) < CELLS, "cell write beyond the buffer")

endmodule

### sv/text_console_cursor_scroll_top.sv
// top level of the text console engine: configuration registers and wiring
// depends on tccs_pkg, tccs_stream_if, tccs_front, tccs_fifo and tccs_back
//
// channel   direction  payload                               handshake
// in_if     sink       operation, character, column, row     valid/ready
// out_if    source     status, cursor_position               valid/ready
// cfg_*     write      cfg_index selects, cfg_wdata 8 bits   cfg_we, no wait
//
// print, newline, move, bad move and unused codes: taken and answered in S_IDLE unless a scroll follows
// tab: take in S_IDLE, TAB_WIDTH blank cells in S_TAB, hand-off to out_if in S_FINISH
// a scroll moves every row up in S_SCROLL and blanks the last row in S_BLANK
// clear: take, one cell written per cycle in S_CLEAR, hand-off to out_if in S_FINISH
// after reset a clearing pass zeroes all COLUMNS*ROWS cells (2000 at 80x25) and holds in_if.ready low
// a two-entry queue lets requests arrive while the back end is busy or out_if stalls
module text_console_cursor_scroll_top import tccs_pkg::*; #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  tccs_stream_if.sink   in_if,
  tccs_stream_if.source out_if,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [7:0]    cfg_wdata
);

  logic [7:0] text_color_r;
  logic [7:0] blank_char_r;
  logic       scroll_en_r;
  cfg_t       cfg;

  logic       push;
  cmd_t       push_cmd;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  cmd_t       q_cmd;
  logic       init_busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= 8'd7;
      blank_char_r <= 8'd32;
      scroll_en_r  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEXT_COLOR: text_color_r <= cfg_wdata;
        CFG_BLANK_CHAR: blank_char_r <= cfg_wdata;
        CFG_SCROLL_EN:  scroll_en_r  <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.text_color      = text_color_r;
  assign cfg.blank_character = blank_char_r;
  assign cfg.scroll_enable   = scroll_en_r;

  // request classification
  tccs_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .in_if (in_if),
    .hold  (init_busy),
    .q_full(q_full),
    .push  (push),
    .cmd   (push_cmd)
  );

  // command queue
  tccs_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .din      (push_cmd),
    .pop      (q_pop),
    .not_empty(q_valid),
    .full     (q_full),
    .dout     (q_cmd)
  );

  // execution and results
  tccs_back #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_WIDTH(TAB_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .init_busy(init_busy),
    .out_if   (out_if)
  );

endmodule
